// ===== hw/rtl/mpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and constants of the min priority queue
// beat structs, status and command codes, cell control group
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    status_t                 status;
    logic signed [KEY_W-1:0] min_key;
  } out_beat_t;

  // per-cell control; ins and ext are broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // insert this cycle
    logic ext;   // extract this cycle
    logic occ;   // cell holds a key
    logic tail;  // cell is the first free slot
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/min_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue: bounded min priority queue of signed keys
// sorted chain of cells, insert or extract-min each beat
// ----------------------------------------------------------------------------
// latency: the result of each input beat is registered in the output register
// throughput: one item per cycle while out_ready takes the output; every cell compares and shifts in parallel
// the output register frees in the cycle its beat is taken, so no bubble
// reset clears the entry count and the output valid; cell keys are not reset
// ----------------------------------------------------------------------------
module min_priority_queue
  import mpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_beat_t        out_data_r;
  out_beat_t        out_data_nxt;

  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    do_ins;
  logic                    do_ext;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic                    cell_gt  [CAPACITY];
  cell_ctrl_t              cell_ctrl [CAPACITY];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign do_ins    = accept && (in_data.cmd == CMD_INSERT) && !full;
  assign do_ext    = accept && (in_data.cmd == CMD_EXTRACT) && !empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] lk;
    logic                    lg;
    logic signed [KEY_W-1:0] rk;

    assign cell_ctrl[i].ins  = do_ins;
    assign cell_ctrl[i].ext  = do_ext;
    assign cell_ctrl[i].occ  = (count_r > CNT_W'(i));
    assign cell_ctrl[i].tail = (count_r == CNT_W'(i));

    if (i == 0) begin : g_head
      assign lk = '0;
      assign lg = 1'b0;
    end else begin : g_body
      assign lk = cell_key[i-1];
      assign lg = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rk = cell_key[i];
    end else begin : g_inner
      assign rk = cell_key[i+1];
    end

    mpq_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .new_key   (in_data.key),
      .left_key  (lk),
      .left_gt   (lg),
      .right_key (rk),
      .key_o     (cell_key[i]),
      .gt_o      (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_ext) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt        = 1'b1;
      out_data_nxt.min_key = '0;
      if (in_data.cmd == CMD_INSERT) begin
        out_data_nxt.status = full ? ST_FULL : ST_INSERTED;
      end else if (empty) begin
        out_data_nxt.status = ST_EMPTY;
      end else begin
        out_data_nxt.status  = ST_EXTRACTED;
        out_data_nxt.min_key = cell_key[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_count : assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("insert did not grow the chain");

  a_head_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
    else $error("head of chain out of order");

  a_ext_key : assert property (@(posedge clk) disable iff (!rst_n)
    do_ext |=> (out_data_r.min_key == $past(cell_key[0])))
    else $error("extracted key is not the chain head");
`endif

endmodule

// ===== hw/rtl/mpq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_cell: one slot of the sorted key chain
// compares its key with the incoming key and shifts with its neighbors
// ----------------------------------------------------------------------------
module mpq_cell
  import mpq_pkg::*;
(
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [KEY_W-1:0] new_key,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic                    left_gt,
  input  logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0] key_o,
  output logic                    gt_o
);

  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  // equal keys stay ahead of the new one
  assign gt_o  = ctrl.occ && (key_r > new_key);
  assign key_o = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        key_nxt = left_key;
      end else if (gt_o || ctrl.tail) begin
        key_nxt = new_key;
      end
    end else if (ctrl.ext) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
